// ----- sv/szpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szpd_pkg
// Types and constants shared by the smoothed z-score peak detector modules.
// ----------------------------------------------------------------------------
package szpd_pkg;

	localparam int SAMPLE_W = 24;
	localparam int INDEX_W  = 24;
	localparam int THRESH_W = 12;
	localparam int WEIGHT_W = 9;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;
	localparam int MUL_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_Z_THRESHOLD      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INFLUENCE_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_GATE      = 2'd2;

	localparam logic [THRESH_W-1:0] Z_THRESHOLD_RST      = 12'd768;
	localparam logic [WEIGHT_W-1:0] INFLUENCE_WEIGHT_RST = 9'd26;
	localparam logic [SAMPLE_W-1:0] GLOBAL_GATE_RST      = 24'd0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE           = 9'd256;
	localparam logic [INDEX_W-1:0]  INDEX_MAX            = 24'hFFFFFF;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                restart;
	} in_item_t;

	typedef struct packed {
		logic                is_event;
		logic                window_ready;
		logic [INDEX_W-1:0]  sample_index;
		logic [SAMPLE_W-1:0] kept_value;
	} out_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                restart;
		logic                ready;
		logic [INDEX_W-1:0]  index;
	} tag_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_FILL,
		BK_DD,
		BK_SS,
		BK_VAR,
		BK_RLO,
		BK_RHI,
		BK_CMP,
		BK_KEPT,
		BK_KK,
		BK_UPD
	} back_state_t;

endpackage

// ----- sv/smoothed_zscore_peak_detector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_zscore_peak_detector_core
// Smoothed z-score peak detector over a sliding window of WINDOW samples.
//
// Input beats (in_valid/in_stall/in_data) carry one unsigned Q16.8 sample and
// a restart flag; each produces exactly one output beat (out_valid/out_stall/
// out_data) with the event flag, window-ready flag, index and kept value.
// Registers z_threshold, influence_weight and global_gate are written through
// cfg_wr_en/cfg_index/cfg_data; the user must write them only while the core
// is idle, and the core does not enforce this. The front end takes a beat into
// a two-entry queue in the cycle it arrives. The back end works one beat at a
// time through a shared 32x32 multiplier, taking a sample still filling the
// window through FILL and UPD and a sample under test through DD, SS, VAR, RLO,
// RHI, CMP, KEPT, KK and UPD; it takes no new beat until the last is done. The
// result register frees the back end to start the next beat while a result
// waits; a stalled receiver holds UPD, the queue fills and in_stall rises.
// Reset clears the window sums, fill count, index and pointer and loads the
// register defaults (3.0, about 0.1, zero); the window RAM needs no clearing.
// ----------------------------------------------------------------------------
module smoothed_zscore_peak_detector_core
	import szpd_pkg::*;
#(
	parameter int WINDOW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int PW = $clog2(WINDOW);
	localparam int DW = $bits(tag_t) + PW;

	logic [THRESH_W-1:0] z_threshold_q;
	logic [WEIGHT_W-1:0] influence_weight_q;
	logic [SAMPLE_W-1:0] global_gate_q;

	logic          push, full, pop, empty;
	tag_t          f_tag, b_tag;
	logic [PW-1:0] f_pos, b_pos;
	logic [DW-1:0] q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_threshold_q      <= Z_THRESHOLD_RST;
			influence_weight_q <= INFLUENCE_WEIGHT_RST;
			global_gate_q      <= GLOBAL_GATE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_Z_THRESHOLD:      z_threshold_q      <= cfg_data[THRESH_W-1:0];
				REG_INFLUENCE_WEIGHT: influence_weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_GLOBAL_GATE:      global_gate_q      <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	szpd_front #(
		.WINDOW (WINDOW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.push     (push),
		.push_tag (f_tag),
		.push_pos (f_pos),
		.full     (full)
	);

	assign q_wdata = {f_tag, f_pos};
	assign b_tag   = tag_t'(q_rdata[DW-1:PW]);
	assign b_pos   = q_rdata[PW-1:0];

	szpd_queue #(
		.WIDTH (DW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (q_wdata),
		.full      (full),
		.pop       (pop),
		.pop_data  (q_rdata),
		.empty     (empty)
	);

	szpd_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_tag         (b_tag),
		.head_pos         (b_pos),
		.empty            (empty),
		.pop              (pop),
		.z_threshold      (z_threshold_q),
		.influence_weight (influence_weight_q),
		.global_gate      (global_gate_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_data         (out_data)
	);

endmodule

// ----- sv/szpd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module szpd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/szpd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szpd_front
// Accepts input beats, tracks series index, fill count and oldest pointer,
// and tags each beat with its window slot for the back end.
// ----------------------------------------------------------------------------
module szpd_front
	import szpd_pkg::*;
#(
	parameter int WINDOW = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  in_item_t                  in_data,
	output logic                      push,
	output tag_t                      push_tag,
	output logic [$clog2(WINDOW)-1:0] push_pos,
	input  logic                      full
);

	localparam int PW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);

	logic [FW-1:0]      fill_q;
	logic [PW-1:0]      ptr_q;
	logic [INDEX_W-1:0] idx_q;

	logic [FW-1:0]      fill_eff;
	logic [PW-1:0]      ptr_eff;
	logic [INDEX_W-1:0] idx_eff;
	logic               ready;
	logic [PW-1:0]      pos;
	logic [PW-1:0]      ptr_next;

	assign in_stall = full;
	assign push     = in_valid && !full;

	always_comb begin
		fill_eff = in_data.restart ? '0 : fill_q;
		ptr_eff  = in_data.restart ? '0 : ptr_q;
		idx_eff  = in_data.restart ? '0 : idx_q;
		ready    = (fill_eff == FW'(WINDOW));
		pos      = ready ? ptr_eff : fill_eff[PW-1:0];
		ptr_next = (pos == PW'(WINDOW - 1)) ? '0 : pos + PW'(1);
		push_tag.sample  = in_data.sample;
		push_tag.restart = in_data.restart;
		push_tag.ready   = ready;
		push_tag.index   = idx_eff;
		push_pos         = pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ptr_q  <= '0;
			idx_q  <= '0;
		end else if (push) begin
			fill_q <= ready ? fill_eff : fill_eff + FW'(1);
			ptr_q  <= ready ? ptr_next : ptr_eff;
			idx_q  <= (idx_eff == INDEX_MAX) ? idx_eff : idx_eff + INDEX_W'(1);
		end
	end

endmodule

// ----- sv/szpd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szpd_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module szpd_queue #(
	parameter int WIDTH = 60
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/szpd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szpd_back
// Runs the window statistics, event test and damping for one tagged beat at
// a time through a shared 32x32 multiplier, and holds the result register.
// ----------------------------------------------------------------------------
module szpd_back
	import szpd_pkg::*;
#(
	parameter int WINDOW = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tag_t                      head_tag,
	input  logic [$clog2(WINDOW)-1:0] head_pos,
	input  logic                      empty,
	output logic                      pop,
	input  logic [THRESH_W-1:0]       z_threshold,
	input  logic [WEIGHT_W-1:0]       influence_weight,
	input  logic [SAMPLE_W-1:0]       global_gate,
	output logic                      out_valid,
	input  logic                      out_stall,
	output out_item_t                 out_data
);

	localparam int PW = $clog2(WINDOW);
	localparam int SW = SAMPLE_W + $clog2(WINDOW);
	localparam int QW = 2 * SAMPLE_W + $clog2(WINDOW);
	localparam int VW = 2 * SW;
	localparam int CW = VW + 24;
	localparam int PRW = 2 * MUL_W;

	back_state_t state_q, state_d;

	tag_t                tag_q;
	logic [PW-1:0]       pos_q;
	logic [SW-1:0]       sum_q;
	logic [QW-1:0]       sq_q;
	logic [SAMPLE_W-1:0] newest_q;
	logic [SAMPLE_W-1:0] old_q;
	logic [VW-1:0]       dd_q;
	logic [VW-1:0]       var_q;
	logic [47:0]         oo_q;
	logic [55:0]         rlo_q;
	logic                event_q;
	logic [SAMPLE_W-1:0] kept_q;
	logic [PRW-1:0]      prod_q;
	logic [23:0]         z2_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [SW-1:0]       wx, distance;
	logic [SAMPLE_W-1:0] diff;
	logic [WEIGHT_W-1:0] weight;
	logic [CW-1:0]       lhs, rhs;
	logic [33:0]         round_up, round_dn;
	logic [25:0]         kept_wide;
	logic                ram_we, ram_re, fire, done_ok;
	logic [SAMPLE_W-1:0] ram_rdata;

	assign done_ok   = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		wx       = SW'(tag_q.sample) * SW'(WINDOW);
		distance = (wx >= sum_q) ? wx - sum_q : sum_q - wx;
		diff   = (tag_q.sample >= newest_q) ? tag_q.sample - newest_q
		                                    : newest_q - tag_q.sample;
		weight = (influence_weight > WEIGHT_ONE) ? WEIGHT_ONE : influence_weight;
		lhs    = CW'(dd_q) << 16;
		rhs    = CW'(rlo_q) + (CW'(prod_q) << 32);
		round_up  = 34'(prod_q[32:0]) + 34'd128;
		round_dn  = 34'(prod_q[32:0]) + 34'd127;
		kept_wide = (tag_q.sample >= newest_q) ? 26'(newest_q) + round_up[33:8]
		                                       : 26'(newest_q) - round_dn[33:8];
	end

	always_comb begin
		case (state_q)
			BK_FILL: begin
				mul_a = MUL_W'(tag_q.sample);
				mul_b = MUL_W'(tag_q.sample);
			end
			BK_DD: begin
				mul_a = MUL_W'(distance);
				mul_b = MUL_W'(distance);
			end
			BK_SS: begin
				mul_a = MUL_W'(sum_q);
				mul_b = MUL_W'(sum_q);
			end
			BK_VAR: begin
				mul_a = MUL_W'(old_q);
				mul_b = MUL_W'(old_q);
			end
			BK_RLO: begin
				mul_a = var_q[MUL_W-1:0];
				mul_b = MUL_W'(z2_q);
			end
			BK_RHI: begin
				mul_a = MUL_W'(var_q[VW-1:MUL_W]);
				mul_b = MUL_W'(z2_q);
			end
			BK_CMP: begin
				mul_a = MUL_W'(weight);
				mul_b = MUL_W'(diff);
			end
			default: begin
				mul_a = MUL_W'(kept_q);
				mul_b = MUL_W'(kept_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		ram_re  = 1'b0;
		fire    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					ram_re  = 1'b1;
					state_d = head_tag.ready ? BK_DD : BK_FILL;
				end
			end
			BK_FILL: state_d = BK_UPD;
			BK_DD:   state_d = BK_SS;
			BK_SS:   state_d = BK_VAR;
			BK_VAR:  state_d = BK_RLO;
			BK_RLO:  state_d = BK_RHI;
			BK_RHI:  state_d = BK_CMP;
			BK_CMP:  state_d = BK_KEPT;
			BK_KEPT: state_d = BK_KK;
			BK_KK:   state_d = BK_UPD;
			BK_UPD: begin
				if (done_ok) begin
					fire    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign ram_we = fire;

	szpd_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (kept_q),
		.re    (ram_re),
		.raddr (head_pos),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		prod_q <= PRW'(mul_a) * PRW'(mul_b);
		z2_q   <= 24'(z_threshold) * 24'(z_threshold);
		if (fire) begin
			out_q.is_event     <= event_q;
			out_q.window_ready <= tag_q.ready;
			out_q.sample_index <= tag_q.index;
			out_q.kept_value   <= kept_q;
		end
		case (state_q)
			BK_IDLE: begin
				tag_q <= head_tag;
				pos_q <= head_pos;
			end
			BK_FILL: begin
				kept_q  <= tag_q.sample;
				event_q <= 1'b0;
			end
			BK_DD:   old_q <= ram_rdata;
			BK_SS:   dd_q  <= prod_q[VW-1:0];
			BK_VAR:  var_q <= VW'(sq_q) * VW'(WINDOW) - prod_q[VW-1:0];
			BK_RLO:  oo_q  <= prod_q[47:0];
			BK_RHI:  rlo_q <= prod_q[55:0];
			BK_CMP:  event_q <= (lhs > rhs) && (tag_q.sample > global_gate);
			BK_KEPT: kept_q  <= event_q ? kept_wide[SAMPLE_W-1:0] : tag_q.sample;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			sq_q        <= '0;
			newest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head_tag.restart) begin
				sum_q    <= '0;
				sq_q     <= '0;
				newest_q <= '0;
			end else if (fire) begin
				newest_q <= kept_q;
				if (tag_q.ready) begin
					sum_q <= sum_q - SW'(old_q) + SW'(kept_q);
					sq_q  <= sq_q - QW'(oo_q) + QW'(prod_q[47:0]);
				end else begin
					sum_q <= sum_q + SW'(kept_q);
					sq_q  <= sq_q + QW'(prod_q[47:0]);
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
